[src/format_string_char_formatter_top_defines.svh]
// Assertion macros for the format character formatter RTL, used by cfmt_seq.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FORMAT_STRING_CHAR_FORMATTER_TOP_DEFINES_SVH
`define FORMAT_STRING_CHAR_FORMATTER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CFMT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CFMT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cfmt_pkg.sv]
// Shared types and constants for the format character formatter.
// No dependencies; used by all cfmt modules and the top level.
`default_nettype none

package cfmt_pkg;

    localparam int ARG_BITS    = 32;
    localparam int COUNT_BITS  = 16;
    localparam int CHAR_BITS   = 8;
    localparam int DIGIT_BITS  = 4;

    // decimal digits of the largest ARG_BITS magnitude (log10(2) ~ 1233/4096)
    localparam int DIGIT_DEPTH   = (ARG_BITS * 1233) / 4096 + 1;
    localparam int DIG_IDX_BITS  = $clog2(DIGIT_DEPTH);
    localparam int DIG_CNT_BITS  = $clog2(DIGIT_DEPTH + 1);
    localparam int BIT_IDX_BITS  = $clog2(ARG_BITS);

    // divide by ten as multiply by rounded-up reciprocal
    localparam int DIV_SHIFT = ARG_BITS + 3;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << DIV_SHIFT) / 64'd10) + 64'd1;
    localparam logic [ARG_BITS-1:0] RECIP = RECIP_FULL[ARG_BITS-1:0];

    localparam logic [CHAR_BITS-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_SPEC_C  = 8'h63;
    localparam logic [CHAR_BITS-1:0] CH_SPEC_D  = 8'h64;
    localparam logic [CHAR_BITS-1:0] CH_SPEC_B  = 8'h62;

    typedef struct packed {
        logic [CHAR_BITS-1:0]       fmt_char;
        logic signed [31:0]         arg_value;
        logic                       fmt_end;
    } fmt_in_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0]       out_char;
        logic                       char_valid;
        logic                       format_error;
        logic [COUNT_BITS-1:0]      total_count;
        logic                       last_of_run;
    } fmt_out_t;

    typedef struct packed {
        logic [ARG_BITS-1:0]        quot;
        logic [DIGIT_BITS-1:0]      rem;
    } div_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_DIV_MUL,
        ST_DIV_SUB,
        ST_SIGN,
        ST_DIGIT,
        ST_BIN
    } cfmt_state_t;

endpackage

`default_nettype wire

[src/cfmt_div10.sv]
// Divide-by-ten unit: registered reciprocal product, with quotient and
// remainder valid in the cycle after a load. Depends on cfmt_pkg.
`default_nettype none

module cfmt_div10 (
    input  wire logic                           clk,
    input  wire logic                           load,
    input  wire logic [cfmt_pkg::ARG_BITS-1:0]  dividend,
    output cfmt_pkg::div_res_t                  div_res
);

    logic [cfmt_pkg::ARG_BITS-1:0]      dvd_reg;
    logic [2*cfmt_pkg::ARG_BITS-1:0]    prod_reg;
    logic [cfmt_pkg::ARG_BITS-1:0]      quot;
    logic [cfmt_pkg::ARG_BITS-1:0]      quot_x10;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvd_reg  <= dividend;
            prod_reg <= (2*cfmt_pkg::ARG_BITS)'(dividend)
                        * (2*cfmt_pkg::ARG_BITS)'(cfmt_pkg::RECIP);
        end
    end

    always_comb
    begin
        quot     = cfmt_pkg::ARG_BITS'(prod_reg >> cfmt_pkg::DIV_SHIFT);
        quot_x10 = (quot << 3) + (quot << 1);
        div_res.quot = quot;
        div_res.rem  = cfmt_pkg::DIGIT_BITS'(dvd_reg - quot_x10);
    end

endmodule

`default_nettype wire

[src/cfmt_outbuf.sv]
// Output register stage between the sequencer and the result channel.
// Depends on cfmt_pkg.
`default_nettype none

module cfmt_outbuf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           res_valid,
    output logic                res_ready,
    input  cfmt_pkg::fmt_out_t  res,
    output logic                out_valid,
    input  wire logic           out_ready,
    output cfmt_pkg::fmt_out_t  out_data
);

    logic               out_valid_reg;
    cfmt_pkg::fmt_out_t out_reg;

    assign res_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

endmodule

`default_nettype wire

[src/cfmt_seq.sv]
// Sequencer: decodes format characters, drives the divide unit for %d, scans bits
// for %b; at most one result per cycle, held while stalled. Depends on cfmt_pkg.
`default_nettype none

`include "format_string_char_formatter_top_defines.svh"

module cfmt_seq (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  cfmt_pkg::fmt_in_t                   in_data,
    output logic                                div_load,
    output logic [cfmt_pkg::ARG_BITS-1:0]       div_dividend,
    input  cfmt_pkg::div_res_t                  div_res,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output cfmt_pkg::fmt_out_t                  res
);

    localparam int A = cfmt_pkg::ARG_BITS;

    cfmt_pkg::cfmt_state_t state_reg, state_next;

    logic                                   pending_reg, pending_next;
    logic                                   discard_reg, discard_next;
    logic [cfmt_pkg::COUNT_BITS-1:0]        count_reg, count_next;
    logic [cfmt_pkg::DIG_CNT_BITS-1:0]      dig_cnt_reg, dig_cnt_next;
    logic [cfmt_pkg::BIT_IDX_BITS-1:0]      bit_idx_reg, bit_idx_next;
    logic                                   seen_reg, seen_next;

    logic [cfmt_pkg::CHAR_BITS-1:0]         ch_reg, ch_next;
    logic                                   sgl_err_reg, sgl_err_next;
    logic                                   last_reg, last_next;
    logic                                   neg_reg, neg_next;
    logic [A-1:0]                           work_reg, work_next;
    logic [cfmt_pkg::DIGIT_BITS-1:0]        dig_stack [cfmt_pkg::DIGIT_DEPTH];

    logic                                   in_fire;
    logic                                   is_pct, is_c, is_d, is_b, spec_bad;
    logic [A-1:0]                           arg_ext, arg_mag;
    logic                                   arg_neg;
    logic                                   res_go;
    logic                                   div_done;
    logic                                   bin_bit, bin_emit, bin_step;
    logic                                   finish;
    logic [cfmt_pkg::COUNT_BITS-1:0]        count_inc;
    logic [cfmt_pkg::DIG_IDX_BITS-1:0]      rd_idx;
    logic [cfmt_pkg::DIGIT_BITS-1:0]        rd_digit;

    assign in_ready = (state_reg == cfmt_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign res_go   = res_valid && res_ready;

    always_comb
    begin
        is_pct   = (in_data.fmt_char == cfmt_pkg::CH_PERCENT);
        is_c     = (in_data.fmt_char == cfmt_pkg::CH_SPEC_C);
        is_d     = (in_data.fmt_char == cfmt_pkg::CH_SPEC_D);
        is_b     = (in_data.fmt_char == cfmt_pkg::CH_SPEC_B);
        spec_bad = !(is_pct || is_c || is_d || is_b);
        arg_ext  = A'(in_data.arg_value);
        arg_neg  = arg_ext[A-1];
        arg_mag  = arg_neg ? (~arg_ext + 1'b1) : arg_ext;
    end

    always_comb
    begin
        div_done  = (div_res.quot == '0)
                    || (dig_cnt_reg == cfmt_pkg::DIG_CNT_BITS'(cfmt_pkg::DIGIT_DEPTH - 1));
        bin_bit   = work_reg[A-1];
        bin_emit  = seen_reg || bin_bit || (bit_idx_reg == '0);
        bin_step  = (state_reg == cfmt_pkg::ST_BIN) && (!bin_emit || res_go);
        count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        rd_idx    = cfmt_pkg::DIG_IDX_BITS'(dig_cnt_reg - 1'b1);
        rd_digit  = dig_stack[rd_idx];
        finish    = ((state_reg == cfmt_pkg::ST_SINGLE) && res_go)
                    || ((state_reg == cfmt_pkg::ST_DIGIT) && res_go && (dig_cnt_reg == 1))
                    || (bin_step && (bit_idx_reg == '0));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfmt_pkg::ST_IDLE:
            begin
                if (in_fire && !discard_reg)
                begin
                    if (pending_reg)
                    begin
                        if (is_d)
                        begin
                            state_next = cfmt_pkg::ST_DIV_MUL;
                        end
                        else if (is_b)
                        begin
                            state_next = cfmt_pkg::ST_BIN;
                        end
                        else
                        begin
                            state_next = cfmt_pkg::ST_SINGLE;
                        end
                    end
                    else if (!is_pct || in_data.fmt_end)
                    begin
                        state_next = cfmt_pkg::ST_SINGLE;
                    end
                end
            end
            cfmt_pkg::ST_SINGLE:
            begin
                if (res_go)
                begin
                    state_next = cfmt_pkg::ST_IDLE;
                end
            end
            cfmt_pkg::ST_DIV_MUL:
            begin
                state_next = cfmt_pkg::ST_DIV_SUB;
            end
            cfmt_pkg::ST_DIV_SUB:
            begin
                if (div_done)
                begin
                    state_next = neg_reg ? cfmt_pkg::ST_SIGN : cfmt_pkg::ST_DIGIT;
                end
            end
            cfmt_pkg::ST_SIGN:
            begin
                if (res_go)
                begin
                    state_next = cfmt_pkg::ST_DIGIT;
                end
            end
            cfmt_pkg::ST_DIGIT:
            begin
                if (res_go && (dig_cnt_reg == 1))
                begin
                    state_next = cfmt_pkg::ST_IDLE;
                end
            end
            cfmt_pkg::ST_BIN:
            begin
                if (bin_step && (bit_idx_reg == '0))
                begin
                    state_next = cfmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfmt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pending_next = pending_reg;
        discard_next = discard_reg;
        count_next   = count_reg;
        dig_cnt_next = dig_cnt_reg;
        bit_idx_next = bit_idx_reg;
        seen_next    = seen_reg;
        ch_next      = ch_reg;
        sgl_err_next = sgl_err_reg;
        last_next    = last_reg;
        neg_next     = neg_reg;
        work_next    = work_reg;

        div_load     = 1'b0;
        div_dividend = work_reg;

        res_valid         = 1'b0;
        res.out_char      = '0;
        res.char_valid    = 1'b1;
        res.format_error  = 1'b0;
        res.total_count   = count_inc;
        res.last_of_run   = 1'b0;

        unique case (state_reg)
            cfmt_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    last_next    = in_data.fmt_end;
                    neg_next     = arg_neg;
                    seen_next    = 1'b0;
                    dig_cnt_next = '0;
                    bit_idx_next = cfmt_pkg::BIT_IDX_BITS'(A - 1);
                    work_next    = (pending_reg && is_d) ? arg_mag : arg_ext;
                    if (pending_reg && is_c)
                    begin
                        ch_next = arg_ext[cfmt_pkg::CHAR_BITS-1:0];
                    end
                    else
                    begin
                        ch_next = in_data.fmt_char;
                    end
                    sgl_err_next = pending_reg ? spec_bad : is_pct;
                    if (discard_reg)
                    begin
                        if (in_data.fmt_end)
                        begin
                            pending_next = 1'b0;
                            discard_next = 1'b0;
                            count_next   = '0;
                        end
                    end
                    else if (pending_reg)
                    begin
                        pending_next = 1'b0;
                        discard_next = spec_bad;
                    end
                    else if (is_pct && !in_data.fmt_end)
                    begin
                        pending_next = 1'b1;
                    end
                end
            end
            cfmt_pkg::ST_SINGLE:
            begin
                res_valid        = 1'b1;
                res.out_char     = sgl_err_reg ? '0 : ch_reg;
                res.char_valid   = !sgl_err_reg;
                res.format_error = sgl_err_reg;
                res.total_count  = sgl_err_reg ? count_reg : count_inc;
                res.last_of_run  = 1'b1;
            end
            cfmt_pkg::ST_DIV_MUL:
            begin
                div_load = 1'b1;
            end
            cfmt_pkg::ST_DIV_SUB:
            begin
                dig_cnt_next = dig_cnt_reg + 1'b1;
                div_load     = !div_done;
                div_dividend = div_res.quot;
            end
            cfmt_pkg::ST_SIGN:
            begin
                res_valid    = 1'b1;
                res.out_char = cfmt_pkg::CH_MINUS;
            end
            cfmt_pkg::ST_DIGIT:
            begin
                res_valid       = 1'b1;
                res.out_char    = cfmt_pkg::CH_ZERO + cfmt_pkg::CHAR_BITS'(rd_digit);
                res.last_of_run = (dig_cnt_reg == 1);
                if (res_go)
                begin
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
            end
            cfmt_pkg::ST_BIN:
            begin
                // leading zeros are skipped; bit 0 always goes out so zero prints "0"
                res_valid       = bin_emit;
                res.out_char    = cfmt_pkg::CH_ZERO + cfmt_pkg::CHAR_BITS'(bin_bit);
                res.last_of_run = (bit_idx_reg == '0);
                if (bin_step)
                begin
                    work_next    = work_reg << 1;
                    bit_idx_next = bit_idx_reg - 1'b1;
                    seen_next    = seen_reg || bin_bit;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        if (res_go && res.char_valid)
        begin
            count_next = count_inc;
        end

        if (finish && last_reg)
        begin
            pending_next = 1'b0;
            discard_next = 1'b0;
            count_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cfmt_pkg::ST_IDLE;
            pending_reg <= 1'b0;
            discard_reg <= 1'b0;
            count_reg   <= '0;
            dig_cnt_reg <= '0;
            bit_idx_reg <= '0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            discard_reg <= discard_next;
            count_reg   <= count_next;
            dig_cnt_reg <= dig_cnt_next;
            bit_idx_reg <= bit_idx_next;
            seen_reg    <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        sgl_err_reg <= sgl_err_next;
        last_reg    <= last_next;
        neg_reg     <= neg_next;
        work_reg    <= work_next;
        if (state_reg == cfmt_pkg::ST_DIV_SUB)
        begin
            dig_stack[dig_cnt_reg[cfmt_pkg::DIG_IDX_BITS-1:0]] <= div_res.rem;
        end
    end

    `CFMT_ASSERT_IMP(a_flags_excl, 1'b1, !(pending_reg && discard_reg), "pending and discard both set")
    `CFMT_ASSERT_IMP(a_digit_avail, (state_reg == cfmt_pkg::ST_DIGIT), (dig_cnt_reg != '0), "digit emit with empty stack")
    `CFMT_ASSERT_NXT(a_count_clear, (res_go && res.last_of_run && last_reg), (count_reg == '0), "count not cleared at end of format")
    `CFMT_ASSERT_IMP(a_res_kind, res_valid, !(res.char_valid && res.format_error), "result is both char and error")

endmodule

`default_nettype wire

[src/format_string_char_formatter_top.sv]
// Format character formatter: one format character per request in, a run
// of emitted characters out. Ports:
//   in_valid/in_ready/in_data   request: fmt_char, arg_value, fmt_end
//   out_valid/out_ready/out_data result: out_char, char_valid, format_error,
//                                total_count, last_of_run (marks the final
//                                result of a request)
// Each request yields zero or more results; last_of_run flags the last one.
// A plain character, %c, %% or an error passes from the SINGLE state into the
// output register; %b starts once leading zeros are skipped, %d once the
// divide loop has built all digits. in_ready is high only while the
// sequencer is idle, one request at a time. A request that yields nothing
// ('%' or discarded text) leaves the sequencer idle; the %b scan walks all 32
// bit positions, one per cycle while the output takes results, and for %d the
// divide-by-ten unit yields one digit a cycle and the digits then go out one
// a cycle, '-' first, while the output takes them.
// Reset clears the specifier, discard and character-count state and empties
// the output register. When the receiver stalls, the result waits in the
// output register and the sequencer holds its place until it is taken.
// Depends on cfmt_pkg, cfmt_seq, cfmt_div10 and cfmt_outbuf.
`default_nettype none

module format_string_char_formatter_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  cfmt_pkg::fmt_in_t   in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output cfmt_pkg::fmt_out_t  out_data
);

    logic                               div_load;
    logic [cfmt_pkg::ARG_BITS-1:0]      div_dividend;
    cfmt_pkg::div_res_t                 div_res;
    logic                               res_valid;
    logic                               res_ready;
    cfmt_pkg::fmt_out_t                 res;

    cfmt_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .div_load     (div_load),
        .div_dividend (div_dividend),
        .div_res      (div_res),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    cfmt_div10 u_div10 (
        .clk      (clk),
        .load     (div_load),
        .dividend (div_dividend),
        .div_res  (div_res)
    );

    cfmt_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for format_string_char_formatter_top: a directed table and random
// format strings, each result checked against the table or an in-bench predictor.
// Depends on cfmt_pkg and the formatter RTL.

module tb_top;

    localparam int LIMIT       = 1_500_000;
    localparam int RAND_ITEMS  = 320;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 40;

    localparam logic [cfmt_pkg::CHAR_BITS-1:0] CH_SPEC_S = 8'h73;
    localparam logic [cfmt_pkg::CHAR_BITS-1:0] CH_SPEC_I = 8'h69;

    typedef struct {
        cfmt_pkg::fmt_in_t  req;
        int                 want_n;   // -1: use the predictor
        cfmt_pkg::fmt_out_t want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    cfmt_pkg::fmt_in_t  in_data;
    logic               out_valid;
    logic               out_ready;
    cfmt_pkg::fmt_out_t out_data;

    logic               rcv_ready;
    logic               hold_active = 1'b0;
    bit                 hold_go = 1'b0;
    bit                 idle_on = 1'b1;
    int                 want_n_drv;
    cfmt_pkg::fmt_out_t want_drv;

    cfmt_pkg::fmt_out_t pending_chars[$];
    cfmt_pkg::fmt_out_t run_chars[$];
    dir_row_t           dir_table[$];

    // predictor state
    bit                              spec_armed = 1'b0;
    bit                              aborted = 1'b0;
    logic [cfmt_pkg::COUNT_BITS-1:0] char_cnt = '0;

    int errors = 0;
    int cycles = 0;
    int rand_done = 0;

    assign out_ready = rcv_ready & ~hold_active;

    format_string_char_formatter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    function automatic cfmt_pkg::fmt_in_t mk_in(logic [cfmt_pkg::CHAR_BITS-1:0] ch,
                                                logic [31:0] arg, logic last);
        cfmt_pkg::fmt_in_t r;
        r.fmt_char  = ch;
        r.arg_value = arg;
        r.fmt_end   = last;
        return r;
    endfunction

    function automatic cfmt_pkg::fmt_out_t mk_out(logic [cfmt_pkg::CHAR_BITS-1:0] ch,
                                                  logic v, logic e,
                                                  logic [cfmt_pkg::COUNT_BITS-1:0] cnt);
        cfmt_pkg::fmt_out_t o;
        o.out_char     = ch;
        o.char_valid   = v;
        o.format_error = e;
        o.total_count  = cnt;
        o.last_of_run  = 1'b1;
        return o;
    endfunction

    function automatic void add_result(logic [cfmt_pkg::CHAR_BITS-1:0] ch, logic v, logic e);
        cfmt_pkg::fmt_out_t o;
        if (v && char_cnt != '1)
            char_cnt++;
        o = mk_out(ch, v, e, char_cnt);
        o.last_of_run = 1'b0;
        run_chars.push_back(o);
    endfunction

    // expected results of one format character, left in run_chars
    function automatic void format_one_char(cfmt_pkg::fmt_in_t r);
        logic [31:0]                     a;
        logic [31:0]                     mag;
        logic [cfmt_pkg::DIGIT_BITS-1:0] digs[$];
        bit                              seen;
        a = r.arg_value;
        seen = 1'b0;
        run_chars.delete();
        if (!aborted)
        begin
            if (spec_armed)
            begin
                spec_armed = 1'b0;
                case (r.fmt_char)
                    cfmt_pkg::CH_SPEC_C:  add_result(a[7:0], 1'b1, 1'b0);
                    cfmt_pkg::CH_PERCENT: add_result(cfmt_pkg::CH_PERCENT, 1'b1, 1'b0);
                    cfmt_pkg::CH_SPEC_D:
                    begin
                        mag = a;
                        if (a[31])
                        begin
                            add_result(cfmt_pkg::CH_MINUS, 1'b1, 1'b0);
                            mag = -a;   // unsigned magnitude, fine for the most negative
                        end
                        do
                        begin
                            digs.push_front(cfmt_pkg::DIGIT_BITS'(mag % 32'd10));
                            mag = mag / 32'd10;
                        end while (mag != 0);
                        foreach (digs[i])
                            add_result(8'(cfmt_pkg::CH_ZERO + digs[i]), 1'b1, 1'b0);
                    end
                    cfmt_pkg::CH_SPEC_B:
                    begin
                        for (int i = 31; i >= 0; i--)
                        begin
                            if (a[i])
                                seen = 1'b1;
                            if (seen)
                                add_result(8'(cfmt_pkg::CH_ZERO + a[i]), 1'b1, 1'b0);
                        end
                        if (!seen)
                            add_result(cfmt_pkg::CH_ZERO, 1'b1, 1'b0);
                    end
                    default:
                    begin
                        add_result(8'h00, 1'b0, 1'b1);
                        aborted = 1'b1;
                    end
                endcase
            end
            else if (r.fmt_char == cfmt_pkg::CH_PERCENT)
            begin
                if (r.fmt_end)
                    add_result(8'h00, 1'b0, 1'b1);
                else
                    spec_armed = 1'b1;
            end
            else
                add_result(r.fmt_char, 1'b1, 1'b0);
        end
        if (run_chars.size() > 0)
            run_chars[run_chars.size() - 1].last_of_run = 1'b1;
        if (r.fmt_end)
        begin
            spec_armed = 1'b0;
            aborted    = 1'b0;
            char_cnt   = '0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_result(cfmt_pkg::fmt_out_t got);
        cfmt_pkg::fmt_out_t want;
        if (pending_chars.size() == 0)
            report_mismatch("unexpected result", 32'(got.out_char), 32'd0);
        else
        begin
            want = pending_chars.pop_front();
            if (got.out_char !== want.out_char)
                report_mismatch("out_char", 32'(got.out_char), 32'(want.out_char));
            if (got.char_valid !== want.char_valid)
                report_mismatch("char_valid", 32'(got.char_valid), 32'(want.char_valid));
            if (got.format_error !== want.format_error)
                report_mismatch("format_error", 32'(got.format_error),
                                32'(want.format_error));
            if (got.total_count !== want.total_count)
                report_mismatch("total_count", 32'(got.total_count), 32'(want.total_count));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
        end
    endtask

    // results are checked before the new request's expectations are queued
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
            begin
                format_one_char(in_data);
                if (want_n_drv < 0)
                begin
                    foreach (run_chars[i])
                        pending_chars.push_back(run_chars[i]);
                end
                else if (want_n_drv == 1)
                    pending_chars.push_back(want_drv);
            end
        end
    end

    task automatic send_req(cfmt_pkg::fmt_in_t r, int want_n, cfmt_pkg::fmt_out_t want);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_data    <= r;
        want_n_drv <= want_n;
        want_drv   <= want;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic add_row(cfmt_pkg::fmt_in_t r, int want_n, cfmt_pkg::fmt_out_t want);
        dir_row_t row;
        row.req    = r;
        row.want_n = want_n;
        row.want   = want;
        dir_table.push_back(row);
    endtask

    function automatic logic [31:0] rand_arg();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return -$urandom_range(1, 99);
            4:       return $urandom_range(0, 99);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_rand(logic [cfmt_pkg::CHAR_BITS-1:0] ch, logic last);
        send_req(mk_in(ch, rand_arg(), last), -1, '0);
        rand_done++;
    endtask

    // one format string: mostly text and valid specifiers, some errors and noise
    task automatic send_string();
        int                             len;
        int                             kind;
        int                             t;
        logic [cfmt_pkg::CHAR_BITS-1:0] ch;
        len = $urandom_range(1, 8);
        t = 0;
        while (t < len)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                do ch = 8'($urandom_range(1, 255)); while (ch == cfmt_pkg::CH_PERCENT);
                send_rand(ch, t == len - 1);
            end
            else if (kind < 85)
            begin
                send_rand(cfmt_pkg::CH_PERCENT, 1'b0);
                case ($urandom_range(0, 3))
                    0:       ch = cfmt_pkg::CH_SPEC_C;
                    1:       ch = cfmt_pkg::CH_SPEC_D;
                    2:       ch = cfmt_pkg::CH_SPEC_B;
                    default: ch = cfmt_pkg::CH_PERCENT;
                endcase
                send_rand(ch, t == len - 1);
            end
            else if (kind < 92)
            begin
                send_rand(cfmt_pkg::CH_PERCENT, 1'b0);
                do ch = 8'($urandom_range(1, 255));
                while (ch == cfmt_pkg::CH_SPEC_C || ch == cfmt_pkg::CH_SPEC_D
                       || ch == cfmt_pkg::CH_SPEC_B || ch == cfmt_pkg::CH_PERCENT);
                send_rand(ch, t == len - 1);
            end
            else if (kind < 96)
            begin
                // trailing percent closes the string
                send_rand(cfmt_pkg::CH_PERCENT, 1'b1);
                t = len;
            end
            else
                send_rand(8'($urandom_range(1, 255)), t == len - 1);
            t++;
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_chars.size() != 0);
    endtask

    initial
    begin : stimulus
        int s;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        want_n_drv <= -1;
        want_drv   <= '0;

        add_row(mk_in(8'h41, 32'd0, 1'b0), 1, mk_out(8'h41, 1'b1, 1'b0, 16'd1));
        add_row(mk_in(8'h00, 32'd0, 1'b0), 1, mk_out(8'h00, 1'b1, 1'b0, 16'd2));
        add_row(mk_in(8'hFF, 32'd0, 1'b0), 1, mk_out(8'hFF, 1'b1, 1'b0, 16'd3));
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b0), 0, '0);
        add_row(mk_in(cfmt_pkg::CH_SPEC_C, 32'h5A5A_A5FF, 1'b0), 1,
                mk_out(8'hFF, 1'b1, 1'b0, 16'd4));
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b0), 0, '0);
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b1), 1,
                mk_out(cfmt_pkg::CH_PERCENT, 1'b1, 1'b0, 16'd5));
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b0), 0, '0);
        add_row(mk_in(cfmt_pkg::CH_SPEC_D, 32'h8000_0000, 1'b1), -1, '0);
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b0), 0, '0);
        add_row(mk_in(cfmt_pkg::CH_SPEC_D, 32'h7FFF_FFFF, 1'b1), -1, '0);
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b0), 0, '0);
        add_row(mk_in(cfmt_pkg::CH_SPEC_D, 32'd0, 1'b0), 1,
                mk_out(cfmt_pkg::CH_ZERO, 1'b1, 1'b0, 16'd1));
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b0), 0, '0);
        add_row(mk_in(cfmt_pkg::CH_SPEC_D, 32'hFFFF_FFFF, 1'b1), -1, '0);
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b0), 0, '0);
        add_row(mk_in(cfmt_pkg::CH_SPEC_B, 32'd0, 1'b0), 1,
                mk_out(cfmt_pkg::CH_ZERO, 1'b1, 1'b0, 16'd1));
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b0), 0, '0);
        add_row(mk_in(cfmt_pkg::CH_SPEC_B, 32'hFFFF_FFFF, 1'b1), -1, '0);
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b1), 1,
                mk_out(8'h00, 1'b0, 1'b1, 16'd0));
        add_row(mk_in(8'h5A, 32'd0, 1'b0), 1, mk_out(8'h5A, 1'b1, 1'b0, 16'd1));
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b0), 0, '0);
        add_row(mk_in(CH_SPEC_S, 32'd0, 1'b0), 1, mk_out(8'h00, 1'b0, 1'b1, 16'd1));
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b1), 0, '0);   // swallowed, ends string
        add_row(mk_in(cfmt_pkg::CH_PERCENT, 32'd0, 1'b0), 0, '0);
        add_row(mk_in(CH_SPEC_I, 32'd0, 1'b1), 1, mk_out(8'h00, 1'b0, 1'b1, 16'd0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            send_req(dir_table[i].req, dir_table[i].want_n, dir_table[i].want);

        s = 0;
        while (rand_done < RAND_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (s == 8)
                hold_go = 1'b1;
            if (s == 20)
                wait_drained();
            send_string();
            s++;
        end

        // let the last request's expectations reach the queue first
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : drain
        int w;
        rcv_ready <= 1'b0;
        forever
        begin
            w = idle_on ? $urandom_range(0, 6) : 0;
            if (w > 0)
            begin
                rcv_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            rcv_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // receiver blocks for a long stretch so requests back up behind the output
    initial
    begin : long_stall
        wait (hold_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active <= 1'b0;
    end

endmodule

[sim.f]
+incdir+src
src/cfmt_pkg.sv
src/cfmt_div10.sv
src/cfmt_outbuf.sv
src/cfmt_seq.sv
src/format_string_char_formatter_top.sv
sim/tb_top.sv
